[design/swerve_inverse_kinematics_top_defines.svh]
// ---------------------------------------------------------------------------
// Swerve inverse kinematics: assertion macros
// Shared checking macros for the swerve inverse kinematics design. They use
// the clk and rst_n names of the module that expands them.
// ---------------------------------------------------------------------------
`ifndef SWERVE_INVERSE_KINEMATICS_TOP_DEFINES_SVH
`define SWERVE_INVERSE_KINEMATICS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIK_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sik check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIK_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sik check failed");

`endif

[design/sik_pkg.sv]
// ---------------------------------------------------------------------------
// Swerve inverse kinematics package
// Field widths, angle constants, the arctangent table and the control bundle
// shared by the top level and the per-wheel datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package sik_pkg;

  // Field widths of the streams and registers.
  localparam int VEL_W     = 32;
  localparam int CFG_W     = 31;
  localparam int ANGLE_W   = 19;
  localparam int RATE_W    = 31;
  localparam int STAMP_W   = 63;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 264;
  localparam int ADDR_W    = 4;
  localparam int PDATA_W   = 32;

  // Register word indexes.
  localparam logic [1:0] REG_HALF_LENGTH  = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH   = 2'd1;
  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd2;

  // Angle arithmetic: table in 30 fraction bits, result in 16.
  localparam int TABLE_FRAC = 30;
  localparam int ANGLE_FRAC = 16;
  localparam int Z_W        = 34;

  localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = 19'sd205887;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 19'sd102944;
  localparam logic signed [Z_W-1:0]     HALF_PI_Q30   = 34'sd1686629713;
  localparam logic signed [Z_W-1:0]     Z_ROUND       = 34'sd8192;

  // atan(2^-i) in 30 fraction bits.
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // Signed width of a contact velocity: a lever product keeps 63 - frac
  // magnitude bits, plus a sign and one bit for the velocity add.
  function automatic int sik_cw(input int frac);
    return 65 - frac;
  endfunction

  // Cycles through one wheel datapath: abs, partial products, squares,
  // sum, one stage per root bit, divider setup, one stage per quotient bit,
  // and the output register.
  function automatic int sik_wheel_lat(input int frac);
    return sik_cw(frac) + RATE_W + 6;
  endfunction

  // Control bundle from the top level to each wheel.
  typedef struct packed {
    logic             en;
    logic [CFG_W-1:0] radius;
  } sik_ctrl_t;

endpackage

`default_nettype wire

[design/sik_wheel.sv]
// ---------------------------------------------------------------------------
// Swerve wheel datapath
// Turns one contact velocity into a steering angle (pipelined CORDIC) and a
// rotation rate (pipelined square root and restoring divider).
// ---------------------------------------------------------------------------
`default_nettype none

module sik_wheel #(
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                          clk,
  input  sik_pkg::sik_ctrl_t                            ctrl,
  input  logic signed [sik_pkg::sik_cw(FRAC_BITS)-1:0]  cx,
  input  logic signed [sik_pkg::sik_cw(FRAC_BITS)-1:0]  cy,
  output logic signed [sik_pkg::ANGLE_W-1:0]            angle,
  output logic        [sik_pkg::RATE_W-1:0]             rate
);
  import sik_pkg::*;

  localparam int CW      = sik_cw(FRAC_BITS);
  localparam int AW      = CW - 1;
  localparam int MW      = AW + 1;
  localparam int H       = (AW + 1) / 2;
  localparam int HW      = AW - H;
  localparam int NW2     = 2 * MW;
  localparam int RW      = MW + 2;
  localparam int NUMW    = MW + FRAC_BITS;
  localparam int LIMW    = MW + RATE_W;
  localparam int XW      = CW + 2;
  localparam int ANG_LAT = ANGLE_ITERATIONS + 2;
  localparam int DLY     = sik_wheel_lat(FRAC_BITS) - ANG_LAT;

  // -------------------------------------------------------------------------
  // Magnitude: absolute values, squares from half-width partial products.
  // -------------------------------------------------------------------------
  logic [AW-1:0]      ax_r, ay_r;
  logic [2*H-1:0]     xll_r, yll_r;
  logic [H+HW-1:0]    xlh_r, ylh_r;
  logic [2*HW-1:0]    xhh_r, yhh_r;
  logic [2*AW-1:0]    sqx_r, sqy_r;
  logic [NW2-1:0]     n_r;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      ax_r  <= AW'((cx < 0) ? -cx : cx);
      ay_r  <= AW'((cy < 0) ? -cy : cy);
      xll_r <= {{H{1'b0}}, ax_r[H-1:0]} * {{H{1'b0}}, ax_r[H-1:0]};
      yll_r <= {{H{1'b0}}, ay_r[H-1:0]} * {{H{1'b0}}, ay_r[H-1:0]};
      xlh_r <= {{HW{1'b0}}, ax_r[H-1:0]} * {{H{1'b0}}, ax_r[AW-1:H]};
      ylh_r <= {{HW{1'b0}}, ay_r[H-1:0]} * {{H{1'b0}}, ay_r[AW-1:H]};
      xhh_r <= {{HW{1'b0}}, ax_r[AW-1:H]} * {{HW{1'b0}}, ax_r[AW-1:H]};
      yhh_r <= {{HW{1'b0}}, ay_r[AW-1:H]} * {{HW{1'b0}}, ay_r[AW-1:H]};
      sqx_r <= ((2*AW)'(xhh_r) << (2*H)) + ((2*AW)'(xlh_r) << (H+1)) + (2*AW)'(xll_r);
      sqy_r <= ((2*AW)'(yhh_r) << (2*H)) + ((2*AW)'(ylh_r) << (H+1)) + (2*AW)'(yll_r);
      n_r   <= NW2'(sqx_r) + NW2'(sqy_r);
    end
  end

  // -------------------------------------------------------------------------
  // Square root, one result bit per stage (restoring, no multiplier).
  // -------------------------------------------------------------------------
  logic [NW2-1:0] sn_r    [MW];
  logic [RW-1:0]  srem_r  [MW];
  logic [MW-1:0]  sroot_r [MW];

  for (genvar k = 0; k < MW; k++) begin : g_sqrt
    logic [NW2-1:0] n_in;
    logic [RW-1:0]  rem_in;
    logic [MW-1:0]  root_in;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;

    if (k == 0) begin : g_first
      assign n_in    = n_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = sn_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], n_in[NW2-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        sn_r[k] <= n_in << 2;
        if (rem_sh >= trial) begin
          srem_r[k]  <= rem_sh - trial;
          sroot_r[k] <= {root_in[MW-2:0], 1'b1};
        end else begin
          srem_r[k]  <= rem_sh;
          sroot_r[k] <= {root_in[MW-2:0], 1'b0};
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Divider setup: zero and overflow checks, first partial remainder.
  // -------------------------------------------------------------------------
  logic [MW-1:0]     mag;
  logic [LIMW-1:0]   mag_ext;
  logic [LIMW-1:0]   rad_lim;
  logic [NUMW-1:0]   num;
  logic              dz_r;
  logic              dovf_r;
  logic [RATE_W:0]   drem_r;
  logic [RATE_W-1:0] dlo_r;

  assign mag     = sroot_r[MW-1];
  assign mag_ext = LIMW'(mag);
  assign rad_lim = LIMW'(ctrl.radius) << (RATE_W - FRAC_BITS);
  assign num     = {mag, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      dz_r   <= (mag == '0);
      dovf_r <= (mag_ext >= rad_lim);
      drem_r <= num[2*RATE_W:RATE_W];
      dlo_r  <= num[RATE_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage.
  // -------------------------------------------------------------------------
  logic [RATE_W:0]   qrem_r [RATE_W];
  logic [RATE_W-1:0] qlo_r  [RATE_W];
  logic [RATE_W-1:0] q_r    [RATE_W];
  logic              qz_r   [RATE_W];
  logic              qovf_r [RATE_W];
  logic [RATE_W:0]   rad_ext;

  assign rad_ext = {1'b0, ctrl.radius};

  for (genvar k = 0; k < RATE_W; k++) begin : g_div
    logic [RATE_W:0]   rem_in;
    logic [RATE_W-1:0] lo_in;
    logic [RATE_W-1:0] q_in;
    logic              z_in;
    logic              ovf_in;
    logic [RATE_W:0]   rem_sh;

    if (k == 0) begin : g_first
      assign rem_in = drem_r;
      assign lo_in  = dlo_r;
      assign q_in   = '0;
      assign z_in   = dz_r;
      assign ovf_in = dovf_r;
    end else begin : g_next
      assign rem_in = qrem_r[k-1];
      assign lo_in  = qlo_r[k-1];
      assign q_in   = q_r[k-1];
      assign z_in   = qz_r[k-1];
      assign ovf_in = qovf_r[k-1];
    end

    assign rem_sh = {rem_in[RATE_W-1:0], lo_in[RATE_W-1]};

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        qlo_r[k]  <= lo_in << 1;
        qz_r[k]   <= z_in;
        qovf_r[k] <= ovf_in;
        if (rem_sh >= rad_ext) begin
          qrem_r[k] <= rem_sh - rad_ext;
          q_r[k]    <= {q_in[RATE_W-2:0], 1'b1};
        end else begin
          qrem_r[k] <= rem_sh;
          q_r[k]    <= {q_in[RATE_W-2:0], 1'b0};
        end
      end
    end
  end

  // Rate register: zero velocity gives zero, overflow saturates.
  logic [RATE_W-1:0] rate_r;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (qz_r[RATE_W-1]) begin
        rate_r <= '0;
      end else if (qovf_r[RATE_W-1]) begin
        rate_r <= '1;
      end else begin
        rate_r <= q_r[RATE_W-1];
      end
    end
  end

  assign rate = rate_r;

  // -------------------------------------------------------------------------
  // Angle: axis cases, quadrant pre-rotation, then vectoring CORDIC.
  // -------------------------------------------------------------------------
  logic signed [XW-1:0]      x0, y0;
  logic signed [Z_W-1:0]     z0;
  logic                      sp0;
  logic signed [ANGLE_W-1:0] spa0;

  always_comb begin
    x0   = XW'(cx);
    y0   = XW'(cy);
    z0   = '0;
    sp0  = (cy == 0) || (cx == 0);
    spa0 = '0;
    if (cx < 0) begin
      if (cy > 0) begin
        x0 = XW'(cy);
        y0 = -XW'(cx);
        z0 = HALF_PI_Q30;
      end else begin
        x0 = -XW'(cy);
        y0 = XW'(cx);
        z0 = -HALF_PI_Q30;
      end
    end
    if (cy == 0) begin
      spa0 = (cx < 0) ? ANGLE_PI : '0;
    end else if (cy > 0) begin
      spa0 = ANGLE_HALF_PI;
    end else begin
      spa0 = -ANGLE_HALF_PI;
    end
  end

  logic signed [XW-1:0]      ix_r, iy_r;
  logic signed [Z_W-1:0]     iz_r;
  logic                      isp_r;
  logic signed [ANGLE_W-1:0] ispa_r;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      ix_r   <= x0;
      iy_r   <= y0;
      iz_r   <= z0;
      isp_r  <= sp0;
      ispa_r <= spa0;
    end
  end

  logic signed [XW-1:0]      cxr_r  [ANGLE_ITERATIONS];
  logic signed [XW-1:0]      cyr_r  [ANGLE_ITERATIONS];
  logic signed [Z_W-1:0]     cz_r   [ANGLE_ITERATIONS];
  logic                      csp_r  [ANGLE_ITERATIONS];
  logic signed [ANGLE_W-1:0] cspa_r [ANGLE_ITERATIONS];

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    logic signed [XW-1:0]      x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]     z_in, step;
    logic                      sp_in;
    logic signed [ANGLE_W-1:0] spa_in;

    if (i == 0) begin : g_first
      assign x_in   = ix_r;
      assign y_in   = iy_r;
      assign z_in   = iz_r;
      assign sp_in  = isp_r;
      assign spa_in = ispa_r;
    end else begin : g_next
      assign x_in   = cxr_r[i-1];
      assign y_in   = cyr_r[i-1];
      assign z_in   = cz_r[i-1];
      assign sp_in  = csp_r[i-1];
      assign spa_in = cspa_r[i-1];
    end

    assign dx   = y_in >>> i;
    assign dy   = x_in >>> i;
    assign step = signed'(Z_W'(ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        csp_r[i]  <= sp_in;
        cspa_r[i] <= spa_in;
        if (y_in >= 0) begin
          cxr_r[i] <= x_in + dx;
          cyr_r[i] <= y_in - dy;
          cz_r[i]  <= z_in + step;
        end else begin
          cxr_r[i] <= x_in - dx;
          cyr_r[i] <= y_in + dy;
          cz_r[i]  <= z_in - step;
        end
      end
    end
  end

  // Round to 16 fraction bits and clamp to +-pi.
  logic signed [Z_W-1:0]     z_sh;
  logic signed [ANGLE_W-1:0] ang_fin;
  logic signed [ANGLE_W-1:0] ang_r;

  assign z_sh = (cz_r[ANGLE_ITERATIONS-1] + Z_ROUND) >>> (TABLE_FRAC - ANGLE_FRAC);

  always_comb begin
    if (csp_r[ANGLE_ITERATIONS-1]) begin
      ang_fin = cspa_r[ANGLE_ITERATIONS-1];
    end else if (z_sh > Z_W'(ANGLE_PI)) begin
      ang_fin = ANGLE_PI;
    end else if (z_sh < -Z_W'(ANGLE_PI)) begin
      ang_fin = -ANGLE_PI;
    end else begin
      ang_fin = ANGLE_W'(z_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      ang_r <= ang_fin;
    end
  end

  // Delay line that lines the angle up with the rate.
  logic signed [ANGLE_W-1:0] ad_r [DLY];

  for (genvar k = 0; k < DLY; k++) begin : g_adly
    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        ad_r[k] <= (k == 0) ? ang_r : ad_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign angle = ad_r[DLY-1];

endmodule

`default_nettype wire

[design/swerve_inverse_kinematics_top.sv]
// ---------------------------------------------------------------------------
// Swerve inverse kinematics top level
// Turns one chassis twist into steering angles and wheel rates for four
// swerve wheels at the corners of a symmetric rectangle.
// ---------------------------------------------------------------------------
// Usage:
// A twist arrives on the in_ stream (vel_x, vel_y, yaw_rate, stamp) and the
// result leaves on the out_ stream (angle and rate per wheel, then stamp).
// Geometry and wheel radius live in three registers on the cfg_ APB port;
// write them only while no twist is in flight.
// The pipeline takes one twist per clock while in_tready is high. A result
// shows on out_tvalid after passing through, in order, the
// lever multiply stages, one stage per square-root bit, one stage per
// quotient bit of the rate divider, and the output register. The CORDIC
// angle path is shorter and is delayed to match.
// When the receiver stalls, the result waits in the output register and one
// more item lands in a skid register; only then does in_tready drop, and the
// whole pipeline holds until the skid register drains.
// Reset clears all valid bits and restores the register defaults
// (half_length 0.5, half_width 0.5, wheel_radius 0.1 in unsigned Q15.16).
// ---------------------------------------------------------------------------
`default_nettype none

module swerve_inverse_kinematics_top #(
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sik_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [sik_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [sik_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready,
  // Twist input: vel_x, vel_y, yaw_rate, stamp, one zero pad bit
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sik_pkg::IN_DATA_W-1:0]     in_tdata,
  // Wheel output: angle_front_left, rate_front_left, angle_front_right,
  // rate_front_right, angle_rear_left, rate_rear_left, angle_rear_right,
  // rate_rear_right, stamp_out, one zero pad bit
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sik_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sik_pkg::*;

  `include "swerve_inverse_kinematics_top_defines.svh"

  localparam int CW  = sik_cw(FRAC_BITS);
  localparam int LW  = CW - 2;
  localparam int PW  = LW + 1;
  localparam int WL  = sik_wheel_lat(FRAC_BITS);
  localparam int TOT = 4 + WL;
  localparam logic [63:0] LEVER_RND = 64'd1 << (FRAC_BITS - 1);

  // -------------------------------------------------------------------------
  // Configuration registers.
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0] half_length_r, half_width_r, wheel_radius_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_length_r  <= 31'd32768;
      half_width_r   <= 31'd32768;
      wheel_radius_r <= 31'd6554;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_HALF_LENGTH:  half_length_r  <= cfg_pwdata[CFG_W-1:0];
        REG_HALF_WIDTH:   half_width_r   <= cfg_pwdata[CFG_W-1:0];
        REG_WHEEL_RADIUS: wheel_radius_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_HALF_LENGTH:  cfg_prdata = {1'b0, half_length_r};
      REG_HALF_WIDTH:   cfg_prdata = {1'b0, half_width_r};
      REG_WHEEL_RADIUS: cfg_prdata = {1'b0, wheel_radius_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Pipeline control: everything advances unless the skid register is full.
  // -------------------------------------------------------------------------
  logic             en;
  logic             skid_valid_r;
  logic [TOT-1:0]   vld_r;
  sik_ctrl_t        wctrl;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign wctrl.en     = en;
  assign wctrl.radius = wheel_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_tvalid};
    end
  end

  // Stamp travels alongside the valid bits.
  logic [STAMP_W-1:0] stamp_r [TOT];

  for (genvar k = 0; k < TOT; k++) begin : g_stamp
    always_ff @(posedge clk) begin
      if (en) begin
        stamp_r[k] <= (k == 0) ? in_tdata[158:96] : stamp_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Lever arms: |yaw_rate| times each half dimension, rounded half away.
  // -------------------------------------------------------------------------
  logic signed [VEL_W-1:0] vx1_r, vy1_r, vx2_r, vy2_r, vx3_r, vy3_r;
  logic [VEL_W-1:0]        awz1_r;
  logic                    wneg1_r, wneg2_r;
  logic [62:0]             prodw2_r, prodl2_r;
  logic [63:0]             rndw, rndl;
  logic [LW-1:0]           magw, magl;
  logic signed [PW-1:0]    pw3_r, pl3_r;

  assign rndw = {1'b0, prodw2_r} + LEVER_RND;
  assign rndl = {1'b0, prodl2_r} + LEVER_RND;
  assign magw = rndw[FRAC_BITS +: LW];
  assign magl = rndl[FRAC_BITS +: LW];

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r    <= signed'(in_tdata[31:0]);
      vy1_r    <= signed'(in_tdata[63:32]);
      awz1_r   <= in_tdata[95] ? (~in_tdata[95:64] + 32'd1) : in_tdata[95:64];
      wneg1_r  <= in_tdata[95];
      vx2_r    <= vx1_r;
      vy2_r    <= vy1_r;
      wneg2_r  <= wneg1_r;
      prodw2_r <= 63'(awz1_r) * 63'(half_width_r);
      prodl2_r <= 63'(awz1_r) * 63'(half_length_r);
      vx3_r    <= vx2_r;
      vy3_r    <= vy2_r;
      pw3_r    <= wneg2_r ? -signed'({1'b0, magw}) : signed'({1'b0, magw});
      pl3_r    <= wneg2_r ? -signed'({1'b0, magl}) : signed'({1'b0, magl});
    end
  end

  // -------------------------------------------------------------------------
  // Contact velocities, wheel order front left, front right, rear left,
  // rear right.
  // -------------------------------------------------------------------------
  logic signed [CW-1:0] cx_r [4];
  logic signed [CW-1:0] cy_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CW'(vx3_r) - CW'(pw3_r);
      cy_r[0] <= CW'(vy3_r) + CW'(pl3_r);
      cx_r[1] <= CW'(vx3_r) + CW'(pw3_r);
      cy_r[1] <= CW'(vy3_r) + CW'(pl3_r);
      cx_r[2] <= CW'(vx3_r) - CW'(pw3_r);
      cy_r[2] <= CW'(vy3_r) - CW'(pl3_r);
      cx_r[3] <= CW'(vx3_r) + CW'(pw3_r);
      cy_r[3] <= CW'(vy3_r) - CW'(pl3_r);
    end
  end

  logic signed [ANGLE_W-1:0] ang_w  [4];
  logic [RATE_W-1:0]         rate_w [4];

  for (genvar w = 0; w < 4; w++) begin : g_wheel
    sik_wheel #(
      .FRAC_BITS        (FRAC_BITS),
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_wheel (
      .clk   (clk),
      .ctrl  (wctrl),
      .cx    (cx_r[w]),
      .cy    (cy_r[w]),
      .angle (ang_w[w]),
      .rate  (rate_w[w])
    );
  end

  // -------------------------------------------------------------------------
  // Output register with skid register.
  // -------------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] res_data;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r;
  logic                  out_valid_r;
  logic                  up_fire;
  logic                  out_load;

  assign res_data = {1'b0, stamp_r[TOT-1],
                     rate_w[3], ang_w[3], rate_w[2], ang_w[2],
                     rate_w[1], ang_w[1], rate_w[0], ang_w[0]};
  assign up_fire  = en && vld_r[TOT-1];
  assign out_load = out_tready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= up_fire;
      end
    end else if (up_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (up_fire) begin
      skid_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // -------------------------------------------------------------------------
  // Checks.
  // -------------------------------------------------------------------------
  `SIK_CHECK(a_skid_needs_out, skid_valid_r, out_valid_r)
  `SIK_CHECK_NEXT(a_stall_holds_pipe, !en, $stable(vld_r))
  `SIK_CHECK(a_skid_only_on_stall, $rose(skid_valid_r), $past(out_valid_r && !out_tready))

endmodule

`default_nettype wire

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// Swerve inverse kinematics testbench
// Drives chassis twists into the block and predicts each wheel's steering
// angle, rotation rate and the passed-through stamp. Every output transfer
// is compared with the oldest prediction. Geometry and radius registers are
// changed between phases, and both stream sides idle at varying rates.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sik_pkg::*;

  // Expected content of one result transfer.
  typedef struct {
    logic signed [ANGLE_W-1:0] angle [4];
    logic [RATE_W-1:0]         rate [4];
    logic [STAMP_W-1:0]        stamp;
  } wheel_cmd_t;

  localparam longint RATE_SAT = 64'd2147483647;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // vel_x, vel_y, yaw_rate, stamp, pad bit (lowest bit first)
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // angle/rate for FL, FR, RL, RR, then stamp_out, pad bit (lowest bit first)
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predictor copy of the registers.
  longint half_length_q = 32768;
  longint half_width_q = 32768;
  longint wheel_radius_q = 6554;

  wheel_cmd_t pending_cmds [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  swerve_inverse_kinematics_top dut (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Twist lever product, rounded half away from zero.
  function automatic longint lever_arm(longint w, longint d);
    longint mag;
    longint p;
    mag = (w < 0) ? -w : w;
    p = (mag * d + 64'd32768) >>> 16;
    return (w < 0) ? -p : p;
  endfunction

  // Exact floor square root of ax^2 + ay^2.
  function automatic longint speed_norm(longint ax, longint ay);
    logic [127:0] n;
    logic [127:0] c;
    logic [127:0] root;
    n = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    root = '0;
    for (int b = 57; b >= 0; b--) begin
      c = root | (128'd1 << b);
      if (c * c <= n) root = c;
    end
    return longint'(root);
  endfunction

  // Rotation rate with saturation.
  function automatic longint spin_rate(longint m);
    longint q;
    longint rem;
    if (m == 0) return 0;
    if (wheel_radius_q == 0) return RATE_SAT;
    q = m / wheel_radius_q;
    rem = m % wheel_radius_q;
    if (q >= (64'd1 << 15)) return RATE_SAT;
    return (q << 16) + (rem << 16) / wheel_radius_q;
  endfunction

  // Steering angle by quadrant pre-rotation and vectoring CORDIC.
  function automatic longint steer_angle(longint x, longint y);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (y == 0) return (x < 0) ? longint'(ANGLE_PI) : 0;
    if (x == 0) return (y > 0) ? longint'(ANGLE_HALF_PI) : -longint'(ANGLE_HALF_PI);
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = longint'(HALF_PI_Q30);
      end else begin
        x = -y; y = t; z = -longint'(HALF_PI_Q30);
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    z = (z + 8192) >>> 14;
    if (z > longint'(ANGLE_PI)) z = ANGLE_PI;
    if (z < -longint'(ANGLE_PI)) z = -longint'(ANGLE_PI);
    return z;
  endfunction

  // Wheel commands for one chassis twist.
  function automatic wheel_cmd_t solve_twist(logic signed [31:0] vx, logic signed [31:0] vy,
                                             logic signed [31:0] wz, logic [STAMP_W-1:0] st);
    wheel_cmd_t r;
    longint pw;
    longint pl;
    longint cx [4];
    longint cy [4];
    pw = lever_arm(wz, half_width_q);
    pl = lever_arm(wz, half_length_q);
    cx[0] = vx - pw; cy[0] = vy + pl;
    cx[1] = vx + pw; cy[1] = vy + pl;
    cx[2] = vx - pw; cy[2] = vy - pl;
    cx[3] = vx + pw; cy[3] = vy - pl;
    for (int k = 0; k < 4; k++) begin
      r.angle[k] = ANGLE_W'(steer_angle(cx[k], cy[k]));
      r.rate[k] = RATE_W'(spin_rate(speed_norm(cx[k] < 0 ? -cx[k] : cx[k],
                                               cy[k] < 0 ? -cy[k] : cy[k])));
    end
    r.stamp = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each output transfer against the oldest prediction.
  always @(posedge clk) begin
    wheel_cmd_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = pending_cmds.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (out_tdata[k*50 +: ANGLE_W] !== e.angle[k])
            report_mismatch($sformatf("wheel %0d angle got %0d want %0d", k,
                            $signed(out_tdata[k*50 +: ANGLE_W]), e.angle[k]));
          if (out_tdata[k*50+ANGLE_W +: RATE_W] !== e.rate[k])
            report_mismatch($sformatf("wheel %0d rate got %0d want %0d", k,
                            out_tdata[k*50+ANGLE_W +: RATE_W], e.rate[k]));
        end
        if (out_tdata[200 +: STAMP_W] !== e.stamp)
          report_mismatch($sformatf("stamp got %0h want %0h",
                          out_tdata[200 +: STAMP_W], e.stamp));
      end
    end
  end

  // Sends one twist and records its prediction at the transfer.
  task automatic send_twist(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] wz, input logic [STAMP_W-1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, st, wz, vy, vx};
    do @(posedge clk); while (!in_tready);
    pending_cmds.push_back(solve_twist(vx, vy, wz, st));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: setup then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_W'(idx) << 2;
    cfg_pwdata <= {1'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_HALF_LENGTH: half_length_q = val;
      REG_HALF_WIDTH: half_width_q = val;
      default: wheel_radius_q = val;
    endcase
  endtask

  task automatic set_geometry(input logic [30:0] len, input logic [30:0] wid,
                              input logic [30:0] rad);
    wait_drained();
    write_reg(REG_HALF_LENGTH, len);
    write_reg(REG_HALF_WIDTH, wid);
    write_reg(REG_WHEEL_RADIUS, rad);
  endtask

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // A velocity value of a randomly picked scale.
  function automatic logic [31:0] rand_speed();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      3: return 32'($signed($urandom_range(2097152)) - 1048576);
      4: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(65536)) - 32768) <<< $urandom_range(15);
    endcase
  endfunction

  task automatic send_random_twist();
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wz;
    vx = rand_speed();
    vy = rand_speed();
    wz = rand_speed();
    // Sometimes pure translation or pure rotation.
    case ($urandom_range(7))
      0: wz = 0;
      1: begin vx = 0; vy = 0; end
      default: ;
    endcase
    send_twist(vx, vy, wz, rand_stamp());
  endtask

  // Axis cases, zero, field extremes and rate saturation.
  task automatic test_directed();
    send_twist(0, 0, 0, '0);
    send_twist(32'h10000, 0, 0, STAMP_MAX);
    send_twist(32'hffff0000, 0, 0, 1);
    send_twist(0, 32'h10000, 0, 2);
    send_twist(0, 32'hffff0000, 0, 3);
    send_twist(0, 0, 32'h10000, 4);
    send_twist(0, 0, 32'hffff0000, 5);
    send_twist(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 6);
    send_twist(32'h80000000, 32'h80000000, 32'h80000000, 7);
    send_twist(32'h80000000, 32'h7fffffff, 0, 8);
    send_twist(32'h7fffffff, 32'h80000000, 32'h7fffffff, 9);
    send_twist(32'h8000, 32'hffff8000, 32'h8000, 10);
    send_twist(32'h10000, 32'h10000, 32'h10000, 11);
    send_twist(1, 1, 1, 12);
    send_twist(32'hffffffff, 32'hffffffff, 32'hffffffff, {STAMP_W{1'b0}} | 63'h2aaa_5555_aaaa_5555);
    send_twist(32'hffff, 0, 0, 63'h5555_aaaa_5555_aaaa);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(1, 31'h7fffffff, 1);
    repeat (15) send_random_twist();
    set_geometry(31'h7fffffff, 1, 31'h7fffffff);
    repeat (15) send_random_twist();
    set_geometry(31'h55555555, 31'h2aaaaaaa, 31'h2aaaaaaa);
    repeat (15) send_random_twist();
    set_geometry(31'h2aaaaaaa, 31'h55555555, 31'h55555555);
    repeat (15) send_random_twist();
  endtask

  // Random twists under each idling pattern, geometry changed per phase.
  task automatic test_idling_phases();
    int idle_pct [4] = '{0, 88, 0, 33};
    int stall_pct [4] = '{0, 0, 88, 33};
    for (int p = 0; p < 4; p++) begin
      set_geometry(31'($urandom_range(200000, 1)), 31'($urandom_range(200000, 1)),
                   31'($urandom_range(100000, 1000)));
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (90) send_random_twist();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Long receiver hold-off while the sender keeps offering more twists than
  // the pipeline holds, so the input stalls; then a full drain.
  task automatic test_backpressure();
    set_geometry(32768, 32768, 6554);
    hold_cycles = 400;
    repeat (120) send_random_twist();
    wait_drained();
    repeat (20) send_random_twist();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_geometry_extremes();
    test_idling_phases();
    test_backpressure();
    wait_drained();
    repeat (120) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
